[src/adpcm_pkg.sv]
`default_nettype none

package adpcm_pkg;

  // field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StepW    = 15;
  localparam int unsigned DivisorW = 10;
  localparam int unsigned ScaleW   = 10;

  // one quotient bit per cycle over the sample magnitude
  localparam int unsigned DivSteps = SampleW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // state limits and reset values
  localparam logic [StepW-1:0]    StepMin      = 15'd127;
  localparam logic [StepW-1:0]    StepMax      = 15'd24576;
  localparam logic [SampleW-1:0]  SigMax       = 16'h7fff;
  localparam logic [SampleW-1:0]  SigMin       = 16'h8000;
  localparam logic [DivisorW-1:0] DivisorReset = 10'd10;

  // input transaction
  typedef struct packed {
    logic                      restart;
    logic [7:0]                code_byte;
    logic                      mix_enable;
    logic signed [SampleW-1:0] mix_first;
    logic signed [SampleW-1:0] mix_second;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic signed [SampleW-1:0] sample_first;
    logic signed [SampleW-1:0] sample_second;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic nib_hi;
    logic nib_lo;
    logic div_load;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // step multiplier picked by the low three code bits
  function automatic logic [ScaleW-1:0] scale_of(input logic [2:0] code);
    logic [ScaleW-1:0] s;
    case (code)
      3'd4:    s = 10'h133;
      3'd5:    s = 10'h199;
      3'd6:    s = 10'h200;
      3'd7:    s = 10'h266;
      default: s = 10'h0e6;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[src/adpcm_ctrl.sv]
`default_nettype none

module adpcm_ctrl import adpcm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output dp_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    NIB_HI,
    NIB_LO,
    DIV_LOAD,
    DIV_RUN,
    WRITE
  } state_e;

  state_e              state_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                out_valid_q;
  logic                out_free;

  // output register can take a new result
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != IDLE);
  assign out_valid_o = out_valid_q;

  // commands decoded from state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == IDLE) && in_valid_i;
    cmd_o.nib_hi   = (state_q == NIB_HI);
    cmd_o.nib_lo   = (state_q == NIB_LO);
    cmd_o.div_load = (state_q == DIV_LOAD);
    cmd_o.div_step = (state_q == DIV_RUN);
    cmd_o.load_out = (state_q == WRITE) && out_free;
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result fills the register, a taken result leaves it
      if ((state_q == WRITE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_valid_i) state_q <= NIB_HI;
        end
        NIB_HI: begin
          state_q <= NIB_LO;
        end
        NIB_LO: begin
          state_q <= DIV_LOAD;
        end
        DIV_LOAD: begin
          cnt_q   <= '0;
          state_q <= DIV_RUN;
        end
        DIV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivSteps - 1)) state_q <= WRITE;
        end
        WRITE: begin
          if (out_free) state_q <= IDLE;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/adpcm_dp.sv]
`default_nettype none

module adpcm_dp import adpcm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  input  wire in_item_t            in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [DivisorW-1:0] cfg_data_i,
  output out_item_t                out_data_o
);

  // configuration and decoder state
  logic [DivisorW-1:0] divisor_q;
  logic [SampleW-1:0]  sig_q, sig_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [SampleW-1:0]  lvl_hi_q;

  // captured transaction
  in_item_t            item_q;

  // divider lanes: dividend shifts into quotient, remainder below divisor
  logic [SampleW-1:0]  quo_q [2];
  logic [DivisorW-1:0] rem_q [2];
  logic                neg_q [2];
  logic [SampleW-1:0]  lane_val [2];

  out_item_t           out_q;

  // nibble update
  logic [3:0]          nib;
  logic [SampleW-1:0]  base_sig;
  logic [StepW-1:0]    base_step;
  logic [3:0]          dmag;
  logic [StepW+3:0]    dprod;
  logic [SampleW-1:0]  delta;
  logic [SampleW+1:0]  sum_u;
  logic signed [SampleW+1:0] sum_s;
  logic [StepW+ScaleW-1:0]   sprod;
  logic [StepW+1:0]    st;
  logic [DivisorW-1:0] div_eff;

  assign nib       = cmd_i.nib_hi ? item_q.code_byte[7:4] : item_q.code_byte[3:0];
  assign base_sig  = (cmd_i.nib_hi && item_q.restart) ? '0 : sig_q;
  assign base_step = (cmd_i.nib_hi && item_q.restart) ? StepMin : step_q;
  assign dmag      = {nib[2:0], 1'b1};
  assign dprod     = (StepW+4)'(base_step) * (StepW+4)'(dmag);
  assign delta     = dprod[StepW+3:3];
  assign sum_u     = nib[3] ? {{2{base_sig[SampleW-1]}}, base_sig} - {2'b00, delta}
                            : {{2{base_sig[SampleW-1]}}, base_sig} + {2'b00, delta};
  assign sum_s     = $signed(sum_u);
  assign sprod     = (StepW+ScaleW)'(base_step) * (StepW+ScaleW)'(scale_of(nib[2:0]));
  assign st        = sprod[StepW+ScaleW-1:8];

  // signal clamp
  always_comb begin
    if (sum_s > $signed({2'b00, SigMax})) begin
      sig_d = SigMax;
    end else if (sum_s < $signed({2'b11, SigMin})) begin
      sig_d = SigMin;
    end else begin
      sig_d = sum_u[SampleW-1:0];
    end
  end

  // step clamp
  always_comb begin
    if (st > {2'b00, StepMax}) begin
      step_d = StepMax;
    end else if (st < {2'b00, StepMin}) begin
      step_d = StepMin;
    end else begin
      step_d = st[StepW-1:0];
    end
  end

  assign div_eff = (divisor_q == '0) ? DivisorW'(1) : divisor_q;

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DivisorReset;
      sig_q     <= '0;
      step_q    <= StepMin;
    end else begin
      if (cfg_we_i) divisor_q <= cfg_data_i;
      if (cmd_i.nib_hi || cmd_i.nib_lo) begin
        sig_q  <= sig_d;
        step_q <= step_d;
      end
    end
  end

  // transaction capture and first level
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= in_data_i;
    if (cmd_i.nib_hi) lvl_hi_q <= sig_d;
  end

  // two restoring divider lanes
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [SampleW-1:0]  lvl;
    logic [SampleW-1:0]  mag;
    logic [DivisorW:0]   trial;
    logic                fits;
    logic [SampleW-1:0]  res;
    logic [SampleW-1:0]  mixin;

    assign lvl   = (l == 0) ? lvl_hi_q : sig_q;
    assign mag   = lvl[SampleW-1] ? (~lvl + 1'b1) : lvl;
    assign trial = {rem_q[l], quo_q[l][SampleW-1]};
    assign fits  = trial >= {1'b0, div_eff};
    assign res   = neg_q[l] ? (~quo_q[l] + 1'b1) : quo_q[l];
    assign mixin = (l == 0) ? item_q.mix_first : item_q.mix_second;

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_load) begin
        quo_q[l] <= mag;
        rem_q[l] <= '0;
        neg_q[l] <= lvl[SampleW-1];
      end else if (cmd_i.div_step) begin
        quo_q[l] <= {quo_q[l][SampleW-2:0], fits};
        rem_q[l] <= fits ? DivisorW'(trial - {1'b0, div_eff}) : trial[DivisorW-1:0];
      end
    end

    // scaled sample or wrapped mix sum
    assign lane_val[l] = item_q.mix_enable ? (mixin + res) : res;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.sample_first  <= lane_val[0];
      out_q.sample_second <= lane_val[1];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

[src/adpcm_nibble_pair_decoder.sv]
// ADPCM nibble-pair decoder.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): one code byte with
// restart flag, mix enable and two mix values. The high nibble is decoded first,
// then the low nibble; each decoded level is divided by the volume divisor
// (truncating toward zero) and optionally added onto its mix value, wrapping.
// Output channel (out_valid_o / out_stall_i, payload out_data_o): one result
// per input transaction, the two samples together.
// Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i): the volume divisor,
// always ready; write it only while the block is idle. Zero acts as one.
// Steps from input accept: the high nibble, then the low nibble, then a divider
// load, then the two parallel one-bit-per-cycle restoring dividers, then the
// write into the output register. A new transaction is accepted only after
// the previous one has been written into the output register.
// Reset: signal level 0, step 127, divisor 10, output empty.
// Receiver stall: the result holds in the output register; the next item is
// still accepted and decoded, and waits before its output write until the
// register is taken.
`default_nettype none

module adpcm_nibble_pair_decoder import adpcm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [DivisorW-1:0] cfg_data_i
);

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // sequencer
  adpcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // decoder, dividers and output register
  adpcm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[verif/adpcm_nibble_pair_decoder_tb.sv]
`default_nettype none

module adpcm_nibble_pair_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adpcm_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  // kinds of code runs used to steer the decoder state
  typedef enum int {
    BurstRandom,
    BurstRise,
    BurstFall,
    BurstDecay
  } burst_e;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [DivisorW-1:0] cfg_data;

  // decoder state as predicted
  int                  pred_level;
  int                  pred_step;
  logic [DivisorW-1:0] pred_divisor;
  out_item_t           expected_samples[$];

  int          mismatches     = 0;
  int          results_seen   = 0;
  int          items_sent     = 0;
  int          restarts_sent  = 0;
  int          divisor_writes = 0;
  int unsigned cycle_count    = 0;
  bit          quiet;

  adpcm_nibble_pair_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one adpcm code: move the level, then rescale the step
  function automatic void advance_nibble(input logic [3:0] code);
    int delta;
    int nxt;
    int scale;
    delta = 2 * int'(code[2:0]) + 1;
    if (code[3]) delta = -delta;
    nxt = pred_level + (pred_step * delta) / 8;
    if (nxt > 32767) nxt = 32767;
    else if (nxt < -32768) nxt = -32768;
    pred_level = nxt;
    case (code[2:0])
      3'd4:    scale = 'h133;
      3'd5:    scale = 'h199;
      3'd6:    scale = 'h200;
      3'd7:    scale = 'h266;
      default: scale = 'h0e6;
    endcase
    nxt = (pred_step * scale) >>> 8;
    if (nxt > int'(StepMax)) nxt = int'(StepMax);
    else if (nxt < int'(StepMin)) nxt = int'(StepMin);
    pred_step = nxt;
  endfunction

  // both samples of one code byte, scaled and optionally mixed
  function automatic out_item_t predict_pair(input in_item_t it);
    out_item_t r;
    int        dv;
    int        first;
    int        second;
    dv = (pred_divisor == '0) ? 1 : int'(pred_divisor);
    if (it.restart) begin
      pred_level = 0;
      pred_step  = int'(StepMin);
    end
    advance_nibble(it.code_byte[7:4]);
    first = pred_level / dv;
    advance_nibble(it.code_byte[3:0]);
    second = pred_level / dv;
    if (it.mix_enable) begin
      first  += int'(it.mix_first);
      second += int'(it.mix_second);
    end
    r.sample_first  = first[SampleW-1:0];
    r.sample_second = second[SampleW-1:0];
    return r;
  endfunction

  // mix value, with the extremes picked often
  function automatic logic [SampleW-1:0] pick_mix();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(input bit restart, input logic [7:0] code,
                                         input bit mix_on);
    in_item_t it;
    it.restart    = restart;
    it.code_byte  = code;
    it.mix_enable = mix_on;
    it.mix_first  = pick_mix();
    it.mix_second = pick_mix();
    return it;
  endfunction

  // nibble that pushes level and step in the chosen direction
  function automatic logic [3:0] burst_nibble(input burst_e kind);
    case (kind)
      BurstRise:  return {1'b0, 1'b1, 2'($urandom)};
      BurstFall:  return {1'b1, 1'b1, 2'($urandom)};
      BurstDecay: return {1'($urandom), 1'b0, 2'($urandom)};
      default:    return 4'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input logic [SampleW-1:0] want,
                                        input logic [SampleW-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected %h actual %h", $time, what, want, got);
    end
  endfunction

  // send one transaction, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_samples.push_back(predict_pair(it));
    items_sent++;
    if (it.restart) restarts_sent++;
  endtask

  // drop valid and let every pending result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [DivisorW-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_divisor = value;
    divisor_writes++;
    cfg_valid <= 1'b0;
  endtask

  // runs of codes of one kind, some starting with a restart
  task automatic run_bursts(input int count);
    int     sent;
    int     len;
    burst_e kind;
    bit     restart;
    sent = 0;
    while (sent < count) begin
      kind = burst_e'($urandom_range(3));
      len  = $urandom_range(4, 20);
      for (int k = 0; k < len && sent < count; k++) begin
        restart = (k == 0) ? ($urandom_range(3) == 0) : ($urandom_range(29) == 0);
        send_item(make_item(restart, {burst_nibble(kind), burst_nibble(kind)},
                            1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  // clamps, mix wrap and every code value at the reset divisor
  task automatic test_directed_edges();
    in_item_t it;
    // restart with a shrinking code hits the step floor
    send_item(make_item(1'b1, 8'h00, 1'b0));
    // largest codes drive step and level to their ceilings, mix wraps upward
    repeat (6) begin
      it = make_item(1'b0, 8'h77, 1'b1);
      it.mix_first  = 16'sh7fff;
      it.mix_second = 16'sh7fff;
      send_item(it);
    end
    // largest negative codes drive the level to its floor, mix wraps downward
    repeat (6) begin
      it = make_item(1'b0, 8'hff, 1'b1);
      it.mix_first  = 16'sh8000;
      it.mix_second = 16'sh8000;
      send_item(it);
    end
    // decaying codes, mix inputs ignored
    send_item(make_item(1'b0, 8'h00, 1'b0));
    send_item(make_item(1'b0, 8'h08, 1'b0));
    send_item(make_item(1'b0, 8'h33, 1'b0));
    send_item(make_item(1'b0, 8'hbb, 1'b0));
    // every nibble value once, with a restart in the middle
    for (int n = 0; n < 8; n++) begin
      send_item(make_item(n == 4, {4'(2 * n), 4'(2 * n + 1)}, 1'(n)));
    end
    wait_idle();
  endtask

  // zero, one and full-scale divisors
  task automatic test_divisor_extremes();
    logic [DivisorW-1:0] picks[3] = '{'0, 10'd1, '1};
    foreach (picks[i]) begin
      write_divisor(picks[i]);
      run_bursts(40);
    end
    wait_idle();
  endtask

  // long random phases, each at its own divisor, one of them without idling
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(1) == 0) write_divisor(10'($urandom_range(1, 16)));
      else write_divisor(10'($urandom_range(1, 1023)));
      quiet = (p == 3);
      run_bursts(285);
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 6);
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        flag_mismatch("unexpected result, sample_first", '0, out_data.sample_first);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample_first !== want.sample_first) begin
          flag_mismatch("sample_first", want.sample_first, out_data.sample_first);
        end
        if (out_data.sample_second !== want.sample_second) begin
          flag_mismatch("sample_second", want.sample_second, out_data.sample_second);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("cycle limit reached with %0d results outstanding", expected_samples.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet        = 1'b0;
    pred_level   = 0;
    pred_step    = int'(StepMin);
    pred_divisor = DivisorReset;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_divisor_extremes();
    test_random_phases();
    repeat (30) @(posedge clk);

    $display("checked %0d of %0d transactions (%0d with restart) over %0d divisor writes",
             results_seen, items_sent, restarts_sent, divisor_writes);
    $display("level and step clamps, mix wrap, zero and full-scale divisors were exercised");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
